// ===== design/pts_pkg.sv =====
// shared types, codes and defaults for the punctuation token scanner
package pts_pkg;

    // defaults for the top-level parameters
    localparam int POS_BITS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // widths of the token fields on the ports
    localparam int KIND_W  = 5;
    localparam int FIELD_W = 16;
    localparam int LEN_W   = 2;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd0;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd1;
    localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd2;
    localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd3;
    localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd4;
    localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd5;
    localparam logic [KIND_W-1:0] KIND_DOT    = 5'd6;
    localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd7;
    localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd8;
    localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd9;
    localparam logic [KIND_W-1:0] KIND_STAR   = 5'd10;
    localparam logic [KIND_W-1:0] KIND_BANG   = 5'd11;
    localparam logic [KIND_W-1:0] KIND_EOF    = 5'd19;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd20;

    // held lookahead byte codes
    localparam logic [2:0] PEND_NONE  = 3'd0;
    localparam logic [2:0] PEND_BANG  = 3'd1;
    localparam logic [2:0] PEND_EQ    = 3'd2;
    localparam logic [2:0] PEND_LT    = 3'd3;
    localparam logic [2:0] PEND_GT    = 3'd4;
    localparam logic [2:0] PEND_SLASH = 3'd5;

    // source characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    // one token as it leaves the block
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic [FIELD_W-1:0] line;
    } t_token;

    // all tokens caused by one source byte
    typedef struct packed {
        t_token tok0;
        t_token tok1;
        logic   two;
    } t_entry;

endpackage

// ===== design/pts_front.sv =====
// front end: accepts source bytes, tracks scanner state and forms token entries
module pts_front
    import pts_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [7:0]   i_ch,
    input  logic         i_full,
    output logic         o_push,
    output t_entry       o_entry
);

    localparam int EXT_W = (POS_BITS > FIELD_W) ? POS_BITS : FIELD_W;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam logic [POS_BITS-1:0] LINE_ONE = POS_BITS'(1);

    logic [2:0]          r_pend, n_pend;
    logic                r_in_comment, n_in_comment;
    logic [POS_BITS-1:0] r_pend_start, n_pend_start;
    logic [POS_BITS-1:0] r_offset, n_offset;
    logic [POS_BITS-1:0] r_line, n_line;

    logic       accept;
    logic       a_valid, b_valid, consumed, eof;
    t_token     tok_a, tok_b;
    logic       is_op, is_single;
    logic [2:0] op_code;
    logic [KIND_W-1:0] single_k, op_kind;

    // low field bits of a position counter
    function automatic logic [FIELD_W-1:0] to_field(input logic [POS_BITS-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[FIELD_W-1:0];
    endfunction

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;

    // byte classification
    always_comb begin
        is_op     = 1'b1;
        op_code   = PEND_NONE;
        case (i_ch)
            CH_BANG:  op_code = PEND_BANG;
            CH_EQ:    op_code = PEND_EQ;
            CH_LT:    op_code = PEND_LT;
            CH_GT:    op_code = PEND_GT;
            CH_SLASH: op_code = PEND_SLASH;
            default:  is_op = 1'b0;
        endcase
        is_single = 1'b1;
        single_k  = KIND_ERROR;
        case (i_ch)
            CH_LPAREN: single_k = KIND_LPAREN;
            CH_RPAREN: single_k = KIND_RPAREN;
            CH_LBRACE: single_k = KIND_LBRACE;
            CH_RBRACE: single_k = KIND_RBRACE;
            CH_SEMI:   single_k = KIND_SEMI;
            CH_COMMA:  single_k = KIND_COMMA;
            CH_DOT:    single_k = KIND_DOT;
            CH_MINUS:  single_k = KIND_MINUS;
            CH_PLUS:   single_k = KIND_PLUS;
            CH_STAR:   single_k = KIND_STAR;
            default:   is_single = 1'b0;
        endcase
    end

    // one-character kind of a held operator: ! = < > map to 11 13 15 17
    assign op_kind = KIND_BANG + {1'b0, r_pend - PEND_BANG, 1'b0};

    // next state and tokens for the current byte
    always_comb begin
        n_pend       = r_pend;
        n_in_comment = r_in_comment;
        n_pend_start = r_pend_start;
        n_offset     = r_offset;
        n_line       = r_line;
        a_valid      = 1'b0;
        b_valid      = 1'b0;
        consumed     = 1'b0;
        eof          = 1'b0;
        tok_a.kind   = op_kind;
        tok_a.start  = to_field(r_pend_start);
        tok_a.length = LEN_W'(1);
        tok_a.line   = to_field(r_line);
        tok_b.kind   = KIND_ERROR;
        tok_b.start  = to_field(r_offset);
        tok_b.length = LEN_W'(1);
        tok_b.line   = to_field(r_line);

        // held lookahead byte resolves first
        if (r_pend != PEND_NONE) begin
            n_pend = PEND_NONE;
            if (r_pend == PEND_SLASH) begin
                if (i_ch == CH_SLASH) begin
                    consumed     = 1'b1;
                    n_in_comment = 1'b1;
                end else begin
                    a_valid    = 1'b1;
                    tok_a.kind = KIND_SLASH;
                end
            end else begin
                a_valid = 1'b1;
                if (i_ch == CH_EQ) begin
                    consumed     = 1'b1;
                    tok_a.kind   = op_kind + KIND_W'(1);
                    tok_a.length = LEN_W'(2);
                end
            end
        end

        // the byte itself
        if (!consumed) begin
            if (i_ch == CH_NUL) begin
                eof          = 1'b1;
                b_valid      = 1'b1;
                tok_b.kind   = KIND_EOF;
                tok_b.length = LEN_W'(0);
                n_pend       = PEND_NONE;
                n_in_comment = 1'b0;
                n_pend_start = '0;
                n_offset     = '0;
                n_line       = LINE_ONE;
            end else if (r_in_comment) begin
                if (i_ch == CH_NL) begin
                    n_in_comment = 1'b0;
                    if (r_line != POS_MAX) n_line = r_line + 1'b1;
                end
            end else if (i_ch inside {CH_SPACE, CH_TAB, CH_CR}) begin
                n_pend = PEND_NONE;
            end else if (i_ch == CH_NL) begin
                if (r_line != POS_MAX) n_line = r_line + 1'b1;
            end else if (is_op) begin
                n_pend       = op_code;
                n_pend_start = r_offset;
            end else begin
                b_valid    = 1'b1;
                tok_b.kind = is_single ? single_k : KIND_ERROR;
            end
        end

        // offset advances and saturates, except on end of source
        if (!eof && (r_offset != POS_MAX)) n_offset = r_offset + 1'b1;
    end

    // pack the tokens of this byte into one queue word
    always_comb begin
        if (a_valid) begin
            o_entry.tok0 = tok_a;
            o_entry.tok1 = tok_b;
            o_entry.two  = b_valid;
        end else begin
            o_entry.tok0 = tok_b;
            o_entry.tok1 = tok_b;
            o_entry.two  = 1'b0;
        end
        o_push = accept && (a_valid || b_valid);
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend       <= PEND_NONE;
            r_in_comment <= 1'b0;
            r_pend_start <= '0;
            r_offset     <= '0;
            r_line       <= LINE_ONE;
        end else if (accept) begin
            r_pend       <= n_pend;
            r_in_comment <= n_in_comment;
            r_pend_start <= n_pend_start;
            r_offset     <= n_offset;
            r_line       <= n_line;
        end
    end

`ifndef SYNTHESIS
    // a held operator and an open comment never coexist
    a_pend_comment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_pend != PEND_NONE) && r_in_comment))
        else $error("held operator inside a comment");

    // line count never reaches zero
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line count wrapped to zero");
`endif

endmodule

// ===== design/pts_queue.sv =====
// short register queue of token entries between front and back end
module pts_queue
    import pts_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

`ifndef SYNTHESIS
    // no write into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    // no read from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

// ===== design/pts_back.sv =====
// back end: output register that sends the one or two tokens of each entry
module pts_back
    import pts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_entry             i_entry,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [KIND_W-1:0]  o_token_kind,
    output logic [FIELD_W-1:0] o_start_offset,
    output logic [LEN_W-1:0]   o_token_length,
    output logic [FIELD_W-1:0] o_line_number,
    output logic               o_last_of_run
);

    logic   r_busy, r_sel;
    t_entry r_ent;
    t_token cur;
    logic   take, finish;

    assign take   = r_busy && !i_stall;
    assign finish = take && (r_sel || !r_ent.two);
    assign o_pop  = !i_empty && (!r_busy || finish);

    // word on the output
    assign cur            = r_sel ? r_ent.tok1 : r_ent.tok0;
    assign o_valid        = r_busy;
    assign o_token_kind   = cur.kind;
    assign o_start_offset = cur.start;
    assign o_token_length = cur.length;
    assign o_line_number  = cur.line;
    assign o_last_of_run  = r_sel || !r_ent.two;

    // entry holding register
    always_ff @(posedge i_clk) begin
        if (o_pop) r_ent <= i_entry;
    end

    // which token of the entry is shown
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sel  <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_sel  <= 1'b0;
        end else if (finish) begin
            r_busy <= 1'b0;
            r_sel  <= 1'b0;
        end else if (take) begin
            r_sel  <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    // second token only shown for entries that carry two
    a_sel_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_sel) |-> r_ent.two)
        else $error("second token of a single-token entry");

    // end of source is zero length and closes its run
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_token_kind == KIND_EOF)) |-> ((o_token_length == '0) && o_last_of_run))
        else $error("malformed eof token");
`endif

endmodule

// ===== design/punctuation_token_scanner_top.sv =====
// Punctuation token scanner: takes one source byte per word and returns tokens
// (kind, start offset, length, line, last-of-run flag). Each accepted byte gives
// zero, one or two tokens; a byte is taken every cycle while the token queue has
// room, and the output side sends one token per cycle unless stalled, so a byte
// that resolves a held operator and also makes a token of its own is sent as two
// tokens. The front end works out all tokens of a byte in the cycle it is accepted
// and writes them as one word into a short queue (QUEUE_DEPTH words); the input
// stalls only while that queue is full. The first token of a byte passes through
// the queue and then the output holding register. A zero byte flushes any held
// operator, sends EOF and restarts offset and line counting; counters saturate at
// 2^POS_BITS - 1 and the ports carry their low 16 bits.
module punctuation_token_scanner_top
    import pts_pkg::*;
#(
    parameter int POS_BITS    = POS_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_ch,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [KIND_W-1:0]  o_token_kind,
    output logic [FIELD_W-1:0] o_start_offset,
    output logic [LEN_W-1:0]   o_token_length,
    output logic [FIELD_W-1:0] o_line_number,
    output logic               o_last_of_run
);

    logic   push, full, pop, empty;
    t_entry push_entry, head_entry;

    // scanner state and classification
    pts_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_ch    (i_ch),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // decoupling queue
    pts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_entry (head_entry)
    );

    // token output
    pts_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_entry        (head_entry),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_line_number  (o_line_number),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
